@@ rtl/fxs_pkg.sv @@
package fxs_pkg;

    localparam int COORD_BITS = 16;
    localparam int FIELD_W    = 16;
    localparam logic [FIELD_W-1:0] COORD_MASK = FIELD_W'((64'd1 << COORD_BITS) - 64'd1);

    // 1/256 grid fixed point
    localparam int FRAC_W  = 8;
    localparam int P_W     = FIELD_W + FRAC_W;
    localparam int LEN_W   = P_W + 1;
    localparam int SQ_W    = 2 * LEN_W;
    localparam int SREM_W  = LEN_W + 3;
    localparam int M_W     = 24;
    localparam int STEP_W  = 21;
    localparam int NUM_W   = P_W + STEP_W;
    localparam int DREM_W  = LEN_W + 1;
    localparam int DIST_W  = 25;

    // floor(m*16/225) == (m*RECIP) >> RECIP_SHIFT for m < 2^24
    localparam int RECIP_W     = 29;
    localparam logic [RECIP_W-1:0] RECIP = 29'd305419897;
    localparam int RECIP_SHIFT = 32;
    localparam int PROD_W      = M_W + RECIP_W;

    // heading boundary table
    localparam int BOUNDS     = 32;
    localparam int HQ_W       = 6;
    localparam int HSTEPS     = 6;
    localparam int TRIG_W     = 37;
    localparam int TRIG_SHIFT = 26;
    localparam logic [63:0] PI_Q62  = 64'hC90FDAA22168C235;
    localparam logic [63:0] ONE_Q62 = 64'h4000000000000000;

    // back pipeline stage map
    localparam int ST_SQ0  = 2;
    localparam int ST_LEN  = ST_SQ0 + LEN_W;
    localparam int ST_DIV0 = ST_LEN + 1;
    localparam int ST_FIN  = ST_DIV0 + STEP_W;
    localparam int N_STG   = ST_FIN + 1;

    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = 2;

    typedef struct packed {
        logic [15:0] pos_x;
        logic [15:0] pos_y;
        logic [7:0]  frac_x;
        logic [7:0]  frac_y;
        logic [15:0] target_x;
        logic [15:0] target_y;
        logic [7:0]  speed;
        logic        already_arrived;
    } fxs_in_t;

    typedef struct packed {
        logic [15:0]       new_x;
        logic [15:0]       new_y;
        logic [7:0]        new_frac_x;
        logic [7:0]        new_frac_y;
        logic              arrived;
        logic              moved;
        logic              reached_now;
        logic [7:0]        heading_byte;
        logic [DIST_W-1:0] distance_moved;
    } fxs_out_t;

    // classified request between front and back
    typedef struct packed {
        logic               held;
        logic               sx;
        logic               sy;
        logic [P_W-1:0]     ax;
        logic [P_W-1:0]     ay;
        logic [P_W-1:0]     px;
        logic [P_W-1:0]     py;
        logic [FIELD_W-1:0] tx;
        logic [FIELD_W-1:0] ty;
        logic [M_W-1:0]     m;
    } fxs_rec_t;

    typedef struct packed {
        fxs_rec_t            r;
        logic                swap;
        logic                zero;
        logic                snap;
        logic [P_W-1:0]      lo;
        logic [P_W-1:0]      hi;
        logic [PROD_W-1:0]   prod;
        logic [STEP_W-1:0]   step;
        logic [2*P_W-1:0]    sqx;
        logic [2*P_W-1:0]    sqy;
        logic [SQ_W-1:0]     sqv;
        logic [SREM_W-1:0]   srem;
        logic [LEN_W-1:0]    root;
        logic [HQ_W-1:0]     hq;
        logic [NUM_W-1:0]    numx;
        logic [NUM_W-1:0]    numy;
        logic [DREM_W-1:0]   drx;
        logic [DREM_W-1:0]   dry;
        logic [STEP_W-1:0]   qx;
        logic [STEP_W-1:0]   qy;
        fxs_out_t            res;
    } fxs_stg_t;

    function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] al, ah, bl, bh, p0, p1, p2, p3, mid, hi, lo;
        al  = {32'd0, a[31:0]};
        ah  = {32'd0, a[63:32]};
        bl  = {32'd0, b[31:0]};
        bh  = {32'd0, b[63:32]};
        p0  = al * bl;
        p1  = al * bh;
        p2  = ah * bl;
        p3  = ah * bh;
        mid = (p0 >> 32) + {32'd0, p1[31:0]} + {32'd0, p2[31:0]};
        hi  = p3 + (p1 >> 32) + (p2 >> 32) + (mid >> 32);
        lo  = (mid << 32) | {32'd0, p0[31:0]};
        return (hi << 2) | (lo >> 62);
    endfunction

    // sine or cosine of boundary j, (2j+1)/512 turn, in Q36
    function automatic logic [TRIG_W-1:0] bnd_trig(input int j, input logic want_cos);
        logic [63:0] t, t2, s, c, ts, tc;
        t  = 64'(2 * j + 1) * (PI_Q62 >> 8);
        t2 = mul_q62(t, t);
        s  = t;
        c  = ONE_Q62;
        ts = t;
        tc = ONE_Q62;
        for (int k = 1; k < 16; k++) begin
            ts = mul_q62(ts, t2) / 64'((2 * k) * (2 * k + 1));
            tc = mul_q62(tc, t2) / 64'((2 * k - 1) * (2 * k));
            if ((k & 1) != 0) begin
                s = s - ts;
                c = c - tc;
            end else begin
                s = s + ts;
                c = c + tc;
            end
        end
        return want_cos ? TRIG_W'(c >> TRIG_SHIFT) : TRIG_W'(s >> TRIG_SHIFT);
    endfunction

endpackage

@@ rtl/fixed_point_step_toward_target_core.sv @@
// A request is loaded into the front register on the accepting edge, then passes through the queue
// and the 50 back stages, the last being the output register.
// Throughput: one request per cycle while the result channel is not stalled; the 25-stage square
// root and 21-stage divide are fully pipelined, one root or quotient bit per stage.
// Reset: rst_n is asynchronous, active low; clears valids, queue and sets update_seconds to 60.
module fixed_point_step_toward_target_core (
    input  logic              clk,
    input  logic              rst_n,
    // request channel
    input  logic              in_valid,
    output logic              in_stall,
    input  fxs_pkg::fxs_in_t  in_data,
    // result channel
    output logic              out_valid,
    input  logic              out_stall,
    output fxs_pkg::fxs_out_t out_data,
    // update_seconds register
    input  logic              cfg_we,
    input  logic [15:0]       cfg_data
);

    // front: masks coordinates, forms the delta vector and speed*seconds
    // product, and holds one classified request.
    fxs_pkg::fxs_rec_t fr_rec;
    fxs_pkg::fxs_rec_t q_head;
    logic              push;
    logic              q_full;
    logic              q_valid;
    logic              pop;

    fxs_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .q_full   (q_full),
        .push     (push),
        .rec      (fr_rec)
    );

    // short queue decouples the front from the back's stall
    fxs_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_data (fr_rec),
        .full    (q_full),
        .pop     (pop),
        .q_valid (q_valid),
        .head    (q_head)
    );

    // back: step by reciprocal multiply, length by pipelined square root,
    // heading by table search, per-axis advance by pipelined divide.
    fxs_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .head      (q_head),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

@@ rtl/fxs_front.sv @@
module fxs_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  fxs_pkg::fxs_in_t in_data,
    input  logic             cfg_we,
    input  logic [15:0]      cfg_data,
    input  logic             q_full,
    output logic             push,
    output fxs_pkg::fxs_rec_t rec
);

    logic [15:0]        upd_reg;
    logic               fr_valid_reg;
    logic               fr_valid_next;
    fxs_pkg::fxs_rec_t  rec_reg;
    fxs_pkg::fxs_rec_t  rec_next;
    logic [15:0]        upd_eff;
    logic [fxs_pkg::P_W:0] dx, dy;
    logic               accept;

    assign in_stall = fr_valid_reg && q_full;
    assign accept   = in_valid && !in_stall;
    assign push     = fr_valid_reg && !q_full;
    assign rec      = rec_reg;

    always_comb
    begin
        upd_eff = (upd_reg == 16'd0) ? 16'd1 : upd_reg;
        rec_next.held = in_data.already_arrived;
        rec_next.px   = {in_data.pos_x & fxs_pkg::COORD_MASK, in_data.frac_x};
        rec_next.py   = {in_data.pos_y & fxs_pkg::COORD_MASK, in_data.frac_y};
        rec_next.tx   = in_data.target_x & fxs_pkg::COORD_MASK;
        rec_next.ty   = in_data.target_y & fxs_pkg::COORD_MASK;
        dx = {1'b0, rec_next.tx, 8'd0} - {1'b0, rec_next.px};
        dy = {1'b0, rec_next.ty, 8'd0} - {1'b0, rec_next.py};
        rec_next.sx = dx[fxs_pkg::P_W];
        rec_next.sy = dy[fxs_pkg::P_W];
        rec_next.ax = dx[fxs_pkg::P_W] ? fxs_pkg::P_W'(-dx) : dx[fxs_pkg::P_W-1:0];
        rec_next.ay = dy[fxs_pkg::P_W] ? fxs_pkg::P_W'(-dy) : dy[fxs_pkg::P_W-1:0];
        rec_next.m  = {8'd0, upd_eff} * {16'd0, in_data.speed};
    end

    always_comb
    begin
        fr_valid_next = fr_valid_reg;
        if (accept)
        begin
            fr_valid_next = 1'b1;
        end
        else if (push)
        begin
            fr_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upd_reg      <= 16'd60;
            fr_valid_reg <= 1'b0;
        end
        else
        begin
            fr_valid_reg <= fr_valid_next;
            if (cfg_we)
            begin
                upd_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rec_reg <= rec_next;
        end
    end

endmodule

@@ rtl/fxs_queue.sv @@
module fxs_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  fxs_pkg::fxs_rec_t wr_data,
    output logic              full,
    input  logic              pop,
    output logic              q_valid,
    output fxs_pkg::fxs_rec_t head
);

    fxs_pkg::fxs_rec_t        ent_reg [fxs_pkg::Q_DEPTH];
    logic [fxs_pkg::Q_AW-1:0] wp_reg, rp_reg;
    logic [fxs_pkg::Q_AW:0]   cnt_reg, cnt_next;

    assign full    = cnt_reg == (fxs_pkg::Q_AW + 1)'(fxs_pkg::Q_DEPTH);
    assign q_valid = cnt_reg != '0;
    assign head    = ent_reg[rp_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push)
            begin
                wp_reg <= wp_reg + 1'b1;
            end
            if (pop)
            begin
                rp_reg <= rp_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ent_reg[wp_reg] <= wr_data;
        end
    end

endmodule

@@ rtl/fxs_back.sv @@
module fxs_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_valid,
    input  fxs_pkg::fxs_rec_t head,
    output logic              pop,
    output logic              out_valid,
    input  logic              out_stall,
    output fxs_pkg::fxs_out_t out_data
);

    localparam int NS = fxs_pkg::N_STG;

    fxs_pkg::fxs_stg_t stg_reg [NS];
    fxs_pkg::fxs_stg_t stg_next [NS];
    logic [NS-1:0]     vld_reg;
    logic              adv;

    logic [fxs_pkg::TRIG_W-1:0] cos_tab [fxs_pkg::BOUNDS];
    logic [fxs_pkg::TRIG_W-1:0] sin_tab [fxs_pkg::BOUNDS];

    genvar g, j;

    for (j = 0; j < fxs_pkg::BOUNDS; j++)
    begin : g_tab
        localparam logic [fxs_pkg::TRIG_W-1:0] CV = fxs_pkg::bnd_trig(j, 1'b1);
        localparam logic [fxs_pkg::TRIG_W-1:0] SV = fxs_pkg::bnd_trig(j, 1'b0);
        assign cos_tab[j] = CV;
        assign sin_tab[j] = SV;
    end

    // whole pipe holds while the last stage waits
    assign adv       = !(vld_reg[NS-1] && out_stall);
    assign pop       = adv && q_valid;
    assign out_valid = vld_reg[NS-1];
    assign out_data  = stg_reg[NS-1].res;

    always_comb
    begin
        stg_next[0]      = '0;
        stg_next[0].r    = head;
        stg_next[0].prod = fxs_pkg::PROD_W'(head.m) * fxs_pkg::PROD_W'(fxs_pkg::RECIP);
        stg_next[0].sqx  = (2 * fxs_pkg::P_W)'(head.ax) * (2 * fxs_pkg::P_W)'(head.ax);
        stg_next[0].sqy  = (2 * fxs_pkg::P_W)'(head.ay) * (2 * fxs_pkg::P_W)'(head.ay);
        stg_next[0].swap = head.ax > head.ay;
        stg_next[0].lo   = (head.ax > head.ay) ? head.ay : head.ax;
        stg_next[0].hi   = (head.ax > head.ay) ? head.ax : head.ay;
    end

    for (g = 1; g < NS; g++)
    begin : g_stg
        if (g < fxs_pkg::ST_LEN)
        begin : g_front_half
            logic [fxs_pkg::SREM_W-1:0] trem, trial;
            logic [fxs_pkg::HQ_W:0]     idx;
            logic [fxs_pkg::P_W+fxs_pkg::TRIG_W-1:0] lhs, rhs;
            always_comb
            begin
                stg_next[g] = stg_reg[g-1];
                trem  = '0;
                trial = '0;
                if (g == 1)
                begin
                    stg_next[g].step = fxs_pkg::STEP_W'(stg_reg[g-1].prod
                                                        >> fxs_pkg::RECIP_SHIFT);
                    stg_next[g].sqv  = fxs_pkg::SQ_W'(stg_reg[g-1].sqx)
                                     + fxs_pkg::SQ_W'(stg_reg[g-1].sqy);
                    stg_next[g].srem = '0;
                    stg_next[g].root = '0;
                end
                else
                begin
                    // one root bit per stage
                    trem  = {stg_reg[g-1].srem[fxs_pkg::SREM_W-3:0],
                             stg_reg[g-1].sqv[fxs_pkg::SQ_W-1 -: 2]};
                    trial = fxs_pkg::SREM_W'({stg_reg[g-1].root, 2'b01});
                    stg_next[g].sqv = {stg_reg[g-1].sqv[fxs_pkg::SQ_W-3:0], 2'b00};
                    if (trem >= trial)
                    begin
                        stg_next[g].srem = trem - trial;
                        stg_next[g].root = {stg_reg[g-1].root[fxs_pkg::LEN_W-2:0], 1'b1};
                    end
                    else
                    begin
                        stg_next[g].srem = trem;
                        stg_next[g].root = {stg_reg[g-1].root[fxs_pkg::LEN_W-2:0], 1'b0};
                    end
                end
                // heading: binary search over the boundary table
                idx = '0;
                lhs = '0;
                rhs = '0;
                if (g <= fxs_pkg::HSTEPS)
                begin
                    idx = (fxs_pkg::HQ_W + 1)'(stg_reg[g-1].hq)
                        + (fxs_pkg::HQ_W + 1)'((fxs_pkg::BOUNDS >> (g - 1)) - 1);
                    lhs = (fxs_pkg::P_W + fxs_pkg::TRIG_W)'(stg_reg[g-1].lo)
                        * (fxs_pkg::P_W + fxs_pkg::TRIG_W)'(cos_tab[idx[4:0]]);
                    rhs = (fxs_pkg::P_W + fxs_pkg::TRIG_W)'(stg_reg[g-1].hi)
                        * (fxs_pkg::P_W + fxs_pkg::TRIG_W)'(sin_tab[idx[4:0]]);
                    if (idx < (fxs_pkg::HQ_W + 1)'(fxs_pkg::BOUNDS) && lhs > rhs)
                    begin
                        stg_next[g].hq = stg_reg[g-1].hq
                                       + fxs_pkg::HQ_W'(fxs_pkg::BOUNDS >> (g - 1));
                    end
                end
            end
        end
        else if (g == fxs_pkg::ST_LEN)
        begin : g_len
            always_comb
            begin
                stg_next[g]      = stg_reg[g-1];
                stg_next[g].zero = stg_reg[g-1].root == '0;
                stg_next[g].snap = fxs_pkg::LEN_W'(stg_reg[g-1].step) >= stg_reg[g-1].root;
                stg_next[g].numx = fxs_pkg::NUM_W'(stg_reg[g-1].r.ax)
                                 * fxs_pkg::NUM_W'(stg_reg[g-1].step);
                stg_next[g].numy = fxs_pkg::NUM_W'(stg_reg[g-1].r.ay)
                                 * fxs_pkg::NUM_W'(stg_reg[g-1].step);
            end
        end
        else if (g < fxs_pkg::ST_FIN)
        begin : g_div
            localparam int K = g - fxs_pkg::ST_DIV0;
            logic [fxs_pkg::DREM_W-1:0] srx, sry, tx, ty, dl;
            always_comb
            begin
                stg_next[g] = stg_reg[g-1];
                dl = {1'b0, stg_reg[g-1].root};
                if (K == 0)
                begin
                    srx = fxs_pkg::DREM_W'(stg_reg[g-1].numx[fxs_pkg::NUM_W-1:fxs_pkg::STEP_W]);
                    sry = fxs_pkg::DREM_W'(stg_reg[g-1].numy[fxs_pkg::NUM_W-1:fxs_pkg::STEP_W]);
                end
                else
                begin
                    srx = stg_reg[g-1].drx;
                    sry = stg_reg[g-1].dry;
                end
                tx = {srx[fxs_pkg::DREM_W-2:0], stg_reg[g-1].numx[fxs_pkg::STEP_W-1-K]};
                ty = {sry[fxs_pkg::DREM_W-2:0], stg_reg[g-1].numy[fxs_pkg::STEP_W-1-K]};
                if (tx >= dl)
                begin
                    stg_next[g].drx = tx - dl;
                    stg_next[g].qx  = {stg_reg[g-1].qx[fxs_pkg::STEP_W-2:0], 1'b1};
                end
                else
                begin
                    stg_next[g].drx = tx;
                    stg_next[g].qx  = {stg_reg[g-1].qx[fxs_pkg::STEP_W-2:0], 1'b0};
                end
                if (ty >= dl)
                begin
                    stg_next[g].dry = ty - dl;
                    stg_next[g].qy  = {stg_reg[g-1].qy[fxs_pkg::STEP_W-2:0], 1'b1};
                end
                else
                begin
                    stg_next[g].dry = ty;
                    stg_next[g].qy  = {stg_reg[g-1].qy[fxs_pkg::STEP_W-2:0], 1'b0};
                end
            end
        end
        else
        begin : g_fin
            logic                   mv, live;
            logic [fxs_pkg::P_W-1:0] nx, ny;
            logic [7:0]             t, hd;
            fxs_pkg::fxs_stg_t      s;
            always_comb
            begin
                s    = stg_reg[g-1];
                live = !s.r.held && s.step != '0;
                mv   = live && !s.zero;
                nx   = s.r.px;
                ny   = s.r.py;
                if (mv && s.snap)
                begin
                    nx = {s.r.tx, 8'd0};
                    ny = {s.r.ty, 8'd0};
                end
                else if (mv)
                begin
                    nx = s.r.sx ? s.r.px - fxs_pkg::P_W'(s.qx) : s.r.px + fxs_pkg::P_W'(s.qx);
                    ny = s.r.sy ? s.r.py - fxs_pkg::P_W'(s.qy) : s.r.py + fxs_pkg::P_W'(s.qy);
                end
                t = s.swap ? 8'd64 - 8'(s.hq) : 8'(s.hq);
                case ({s.r.sx, s.r.sy})
                    2'b00:   hd = t;
                    2'b01:   hd = 8'd128 - t;
                    2'b10:   hd = 8'd0 - t;
                    default: hd = t + 8'd128;
                endcase
                stg_next[g]                    = s;
                stg_next[g].res.new_x          = nx[fxs_pkg::P_W-1:fxs_pkg::FRAC_W];
                stg_next[g].res.new_y          = ny[fxs_pkg::P_W-1:fxs_pkg::FRAC_W];
                stg_next[g].res.new_frac_x     = nx[fxs_pkg::FRAC_W-1:0];
                stg_next[g].res.new_frac_y     = ny[fxs_pkg::FRAC_W-1:0];
                stg_next[g].res.arrived        = s.r.held || (live && (s.zero || s.snap));
                stg_next[g].res.moved          = mv;
                stg_next[g].res.reached_now    = mv && s.snap;
                stg_next[g].res.heading_byte   = mv ? hd : 8'd0;
                stg_next[g].res.distance_moved = !mv ? '0 :
                    (s.snap ? fxs_pkg::DIST_W'(s.root) : fxs_pkg::DIST_W'(s.step));
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[NS-2:0], pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < NS; i++)
            begin
                stg_reg[i] <= stg_next[i];
            end
        end
    end

endmodule

@@ rtl/fxs_check.sv @@
module fxs_check (
    input logic              clk,
    input logic              rst_n,
    input logic              out_valid,
    input logic              out_stall,
    input fxs_pkg::fxs_out_t out_data
);

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(out_data))
        else $error("result changed while stalled");

    a_still: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.moved |->
            out_data.heading_byte == 8'd0 && out_data.distance_moved == '0
            && !out_data.reached_now)
        else $error("unmoved unit reports motion");

    a_snap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.reached_now |->
            out_data.arrived && out_data.new_frac_x == 8'd0 && out_data.new_frac_y == 8'd0)
        else $error("snap without clean arrival");

endmodule

bind fixed_point_step_toward_target_core fxs_check u_fxs_check (.*);

@@ tb/fixed_point_step_toward_target_core_tb.sv @@
`timescale 1ns / 100ps

module fixed_point_step_toward_target_core_tb;

    localparam int LATENCY   = 52;
    localparam int CYC_LIMIT = 600000;
    localparam int N_BND     = 32;
    localparam logic [63:0] PI_FX  = 64'hC90FDAA22168C235;
    localparam logic [63:0] ONE_FX = 64'h4000000000000000;

    typedef struct {
        fxs_pkg::fxs_in_t  d;
        bit                known;
        fxs_pkg::fxs_out_t e;
    } dir_row_t;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_stall;
    fxs_pkg::fxs_in_t  in_data;
    logic              out_valid;
    logic              out_stall;
    fxs_pkg::fxs_out_t out_data;
    logic              cfg_we;
    logic [15:0]       cfg_data;

    // local copy of the update_seconds register
    logic [15:0]       upd_secs;
    logic [63:0]       bnd_cos_t [N_BND];
    logic [63:0]       bnd_sin_t [N_BND];

    fxs_pkg::fxs_out_t step_q [$];
    // directed rows carry a typed-in expectation alongside
    bit                known_q [$];
    fxs_pkg::fxs_out_t typed_q [$];

    int   send_idle_pct;
    int   recv_stall_pct;
    int   hold_len;
    int   hold_seq;
    int   hold_seen;
    int   hold_cnt;
    int   mismatches = 0;
    int   results_seen = 0;
    int   cycles = 0;
    int   snaps_seen = 0;
    int   partial_seen = 0;

    fixed_point_step_toward_target_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // exact floor((a*b) / 2^62)
    function automatic logic [63:0] fx_mul62(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[125:62];
    endfunction

    // sine/cosine of (2j+1)/512 turn, series with per-term truncation, kept in Q36
    task automatic build_bounds();
        logic [63:0] t, t2, s, c, ts, tc;
        for (int j = 0; j < N_BND; j++)
        begin
            t  = 64'(2 * j + 1) * (PI_FX >> 8);
            t2 = fx_mul62(t, t);
            s  = t;
            c  = ONE_FX;
            ts = t;
            tc = ONE_FX;
            for (int k = 1; k < 16; k++)
            begin
                ts = fx_mul62(ts, t2) / 64'((2 * k) * (2 * k + 1));
                tc = fx_mul62(tc, t2) / 64'((2 * k - 1) * (2 * k));
                if (k % 2 == 1)
                begin
                    s = s - ts;
                    c = c - tc;
                end
                else
                begin
                    s = s + ts;
                    c = c + tc;
                end
            end
            bnd_sin_t[j] = s >> 26;
            bnd_cos_t[j] = c >> 26;
        end
    endtask

    // boundaries strictly below the direction lo/hi, 0 <= lo <= hi
    function automatic int octant_count(input logic [63:0] lo, input logic [63:0] hi);
        int n;
        logic [127:0] l, h;
        n = 0;
        for (int j = 0; j < N_BND; j++)
        begin
            l = {64'd0, lo} * {64'd0, bnd_cos_t[j]};
            h = {64'd0, hi} * {64'd0, bnd_sin_t[j]};
            if (l > h)
                n++;
        end
        return n;
    endfunction

    function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
        logic [63:0] r, cand;
        r = '0;
        for (int b = 31; b >= 0; b--)
        begin
            cand = r | (64'd1 << b);
            if (cand * cand <= v)
                r = cand;
        end
        return r;
    endfunction

    function automatic fxs_pkg::fxs_out_t advance_unit(input fxs_pkg::fxs_in_t d,
                                                        input logic [15:0] secs);
        fxs_pkg::fxs_out_t o;
        logic [63:0] upd, stp, px, py, tx, ty, ax, ay, len, qx, qy, nx, ny;
        logic        neg_x, neg_y;
        int          t;
        upd = (secs == 0) ? 64'd1 : {48'd0, secs};
        stp = {56'd0, d.speed} * 64'd256 * upd / 64'd3600;
        o = '0;
        o.new_x      = d.pos_x;
        o.new_y      = d.pos_y;
        o.new_frac_x = d.frac_x;
        o.new_frac_y = d.frac_y;
        o.arrived    = d.already_arrived;
        if (!d.already_arrived && stp != 0)
        begin
            px = {d.pos_x, d.frac_x};
            py = {d.pos_y, d.frac_y};
            tx = {d.target_x, 8'd0};
            ty = {d.target_y, 8'd0};
            neg_x = tx < px;
            neg_y = ty < py;
            ax = neg_x ? px - tx : tx - px;
            ay = neg_y ? py - ty : ty - py;
            len = floor_sqrt(ax * ax + ay * ay);
            if (len == 0)
                o.arrived = 1'b1;
            else
            begin
                if (stp >= len)
                begin
                    o.new_x = d.target_x;
                    o.new_y = d.target_y;
                    o.new_frac_x = 8'd0;
                    o.new_frac_y = 8'd0;
                    o.arrived = 1'b1;
                    o.reached_now = 1'b1;
                    o.distance_moved = len[24:0];
                end
                else
                begin
                    qx = ax * stp / len;
                    qy = ay * stp / len;
                    nx = neg_x ? px - qx : px + qx;
                    ny = neg_y ? py - qy : py + qy;
                    {o.new_x, o.new_frac_x} = nx[23:0];
                    {o.new_y, o.new_frac_y} = ny[23:0];
                    o.distance_moved = stp[24:0];
                end
                // angle measured from north toward east
                if (ax <= ay)
                    t = octant_count(ax, ay);
                else
                    t = 64 - octant_count(ay, ax);
                if (!neg_x)
                    o.heading_byte = neg_y ? 8'(128 - t) : 8'(t);
                else
                    o.heading_byte = neg_y ? 8'(t + 128) : 8'(256 - t);
                o.moved = 1'b1;
            end
        end
        return o;
    endfunction

    // request monitor: predict on every accepted request
    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
            step_q.insert(step_q.size(), advance_unit(in_data, upd_secs));
    end

    // result checker
    always @(posedge clk)
    begin
        fxs_pkg::fxs_out_t e;
        bit kn;
        fxs_pkg::fxs_out_t ty;
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            if (step_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: result with nothing pending: %p", out_data);
            end
            else
            begin
                e  = step_q.pop_front();
                kn = known_q.size() ? known_q.pop_front() : 1'b0;
                ty = typed_q.size() ? typed_q.pop_front() : e;
                if (kn)
                    e = ty;
                if (out_data.reached_now)
                    snaps_seen++;
                else if (out_data.moved)
                    partial_seen++;
                if (out_data.new_x !== e.new_x || out_data.new_y !== e.new_y
                    || out_data.new_frac_x !== e.new_frac_x
                    || out_data.new_frac_y !== e.new_frac_y
                    || out_data.arrived !== e.arrived || out_data.moved !== e.moved
                    || out_data.reached_now !== e.reached_now
                    || out_data.heading_byte !== e.heading_byte
                    || out_data.distance_moved !== e.distance_moved)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: result %0d exp %p got %p", results_seen, e, out_data);
                end
            end
        end
    end

    // receiver: random stall, or a long hold-off when the stimulus asks for one
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            hold_cnt  <= 0;
            hold_seen <= 0;
        end
        else if (hold_seen != hold_seq)
        begin
            hold_seen <= hold_seq;
            hold_cnt  <= hold_len;
            out_stall <= 1'b1;
        end
        else if (hold_cnt > 0)
        begin
            hold_cnt  <= hold_cnt - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYC_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // one request with random idle ahead of it
    task automatic send_request(input fxs_pkg::fxs_in_t d);
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        in_valid <= 1'b1;
        in_data  <= d;
        do
            @(posedge clk);
        while (!(in_valid && !in_stall));
    endtask

    // waits on a clock edge first so the last accepted request is already predicted
    task automatic drain_all();
        in_valid <= 1'b0;
        @(posedge clk);
        while (step_q.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 8) @(posedge clk);
    endtask

    // register written only with the pipeline empty
    task automatic set_update_secs(input logic [15:0] v);
        drain_all();
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we   <= 1'b0;
        upd_secs = v;
    endtask

    function automatic fxs_pkg::fxs_in_t rand_unit();
        fxs_pkg::fxs_in_t d;
        logic [127:0] rb;
        int kind;
        rb = {$urandom, $urandom, $urandom, $urandom};
        d = rb[$bits(fxs_pkg::fxs_in_t)-1:0];
        kind = $urandom_range(99);
        if (kind < 35)
        begin
            // near the target: snaps and short partial moves
            d.target_x = d.pos_x + 16'($urandom_range(0, 40)) - 16'd20;
            d.target_y = d.pos_y + 16'($urandom_range(0, 40)) - 16'd20;
        end
        else if (kind < 45)
        begin
            // axis-aligned or diagonal headings
            case ($urandom_range(2))
                0: d.target_x = d.pos_x;
                1: d.target_y = d.pos_y;
                default: d.target_y = d.pos_y + (d.target_x - d.pos_x);
            endcase
        end
        else if (kind < 50)
        begin
            d.target_x = d.pos_x;
            d.target_y = d.pos_y;
            d.frac_x   = ($urandom_range(1)) ? 8'd0 : d.frac_x;
            d.frac_y   = 8'd0;
        end
        d.already_arrived = ($urandom_range(99) < 10);
        if ($urandom_range(99) < 5)
            d.speed = 8'd0;
        return d;
    endfunction

    task automatic random_phase(input int n, input int idle_pct, input int stall_pct);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int i = 0; i < n; i++)
            send_request(rand_unit());
    endtask

    function automatic fxs_pkg::fxs_in_t mk_in(input int px, input int py, input int fx,
                                               input int fy, input int tx, input int ty,
                                               input int spd, input bit held);
        fxs_pkg::fxs_in_t d;
        d = '{16'(px), 16'(py), 8'(fx), 8'(fy), 16'(tx), 16'(ty), 8'(spd), held};
        return d;
    endfunction

    // position passes through untouched
    function automatic fxs_pkg::fxs_out_t stay_put(input fxs_pkg::fxs_in_t d, input bit arr);
        fxs_pkg::fxs_out_t o;
        o = '0;
        o.new_x = d.pos_x;
        o.new_y = d.pos_y;
        o.new_frac_x = d.frac_x;
        o.new_frac_y = d.frac_y;
        o.arrived = arr;
        return o;
    endfunction

    initial
    begin
        dir_row_t rows [$];
        dir_row_t r;
        fxs_pkg::fxs_in_t d;

        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        cfg_we = 1'b0;
        cfg_data = '0;
        upd_secs = 16'd60;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_len = 0;
        hold_seq = 0;
        build_bounds();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // holding unit, zero speed and zero length rows have typed-in results
        d = mk_in(65535, 65535, 255, 255, 0, 0, 255, 1);
        rows.insert(rows.size(), '{d, 1'b1, stay_put(d, 1'b1)});
        d = mk_in(0, 0, 0, 0, 65535, 65535, 255, 1);
        rows.insert(rows.size(), '{d, 1'b1, stay_put(d, 1'b1)});
        d = mk_in(100, 200, 17, 3, 5000, 9, 0, 0);
        rows.insert(rows.size(), '{d, 1'b1, stay_put(d, 1'b0)});
        d = mk_in(1234, 4321, 0, 0, 1234, 4321, 255, 0);
        rows.insert(rows.size(), '{d, 1'b1, stay_put(d, 1'b1)});
        d = mk_in(65535, 0, 0, 0, 65535, 0, 1, 0);
        rows.insert(rows.size(), '{d, 1'b1, stay_put(d, 1'b1)});
        // predictor-checked rows: extremes, cardinal and diagonal headings, snaps
        rows.insert(rows.size(), '{mk_in(0, 0, 0, 0, 65535, 65535, 255, 0), 1'b0, '0});
        rows.insert(rows.size(), '{mk_in(65535, 65535, 255, 255, 0, 0, 255, 0), 1'b0, '0});
        rows.insert(rows.size(), '{mk_in(0, 65535, 0, 0, 65535, 0, 255, 0), 1'b0, '0});
        rows.insert(rows.size(), '{mk_in(65535, 0, 255, 0, 0, 65535, 1, 0), 1'b0, '0});
        rows.insert(rows.size(), '{mk_in(1000, 1000, 0, 0, 1000, 9000, 100, 0), 1'b0, '0});
        rows.insert(rows.size(), '{mk_in(1000, 1000, 0, 0, 9000, 1000, 100, 0), 1'b0, '0});
        rows.insert(rows.size(), '{mk_in(1000, 1000, 0, 0, 1000, 10, 100, 0), 1'b0, '0});
        rows.insert(rows.size(), '{mk_in(1000, 1000, 0, 0, 10, 1000, 100, 0), 1'b0, '0});
        rows.insert(rows.size(), '{mk_in(500, 500, 0, 0, 900, 900, 50, 0), 1'b0, '0});
        rows.insert(rows.size(), '{mk_in(500, 500, 0, 0, 100, 900, 50, 0), 1'b0, '0});
        rows.insert(rows.size(), '{mk_in(500, 500, 0, 0, 100, 100, 50, 0), 1'b0, '0});
        rows.insert(rows.size(), '{mk_in(10, 10, 128, 128, 10, 11, 255, 0), 1'b0, '0});
        rows.insert(rows.size(), '{mk_in(10, 10, 255, 255, 11, 11, 255, 0), 1'b0, '0});
        rows.insert(rows.size(), '{mk_in(10, 10, 1, 0, 10, 10, 200, 0), 1'b0, '0});
        rows.insert(rows.size(), '{mk_in(300, 300, 0, 0, 301, 302, 1, 0), 1'b0, '0});
        rows.insert(rows.size(), '{mk_in(300, 300, 0, 0, 550, 400, 15, 0), 1'b0, '0});

        foreach (rows[i])
        begin
            r = rows[i];
            known_q.insert(known_q.size(), r.known);
            typed_q.insert(typed_q.size(), r.e);
            send_request(r.d);
        end

        // register corners; the zero value behaves as one
        set_update_secs(16'd1);
        random_phase(120, 0, 0);
        set_update_secs(16'd65535);
        random_phase(120, 82, 0);
        set_update_secs(16'd0);
        random_phase(120, 0, 82);
        set_update_secs(16'($urandom_range(1, 65535)));
        random_phase(140, 20, 20);
        set_update_secs(16'd3600);
        random_phase(100, 0, 0);

        // long receiver hold-off while requests keep coming, to back up the pipe
        hold_len = 400;
        hold_seq = hold_seq + 1;
        random_phase(100, 0, 0);

        // sender waits for every pending result, then one more burst
        drain_all();
        set_update_secs(16'd60);
        random_phase(50, 20, 20);

        drain_all();
        $display("Run covered %0d results (%0d snaps, %0d partial moves) over six register values",
                 results_seen, snaps_seen, partial_seen);
        $display("with idle, stall, hold-off and drain phases; %0d mismatches", mismatches);
        if (mismatches == 0 && step_q.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

@@ files.f @@
rtl/fxs_pkg.sv
rtl/fxs_front.sv
rtl/fxs_queue.sv
rtl/fxs_back.sv
rtl/fixed_point_step_toward_target_core.sv
rtl/fxs_check.sv
tb/fixed_point_step_toward_target_core_tb.sv
